// ----- design/mtf_pkg.sv -----
// Shared constants and codes for the move-to-front recency list.
`default_nettype none

package mtf_pkg;

    // Number of list entries held in the tag memory.
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths of the words on the two channels.
    localparam int TAG_W   = 16;
    localparam int STEPS_W = 16;
    localparam int BIT_W   = $clog2(STEPS_W);
    localparam int LEN_W   = 7;
    localparam int STAT_W  = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SWITCH = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- design/move_to_front_recency_list.sv -----
// Top level of the move-to-front recency list: tag memory, walker and result register.
// The block keeps an ordered list of 16-bit tags, most recent at the front.
// Input words arrive on item_valid/item_ready with func, tag and steps; every
// accepted word yields exactly one result word on result_valid/result_ready
// carrying front_tag, list_length and status.
// The list lives in one synchronous memory used as a ring: a head pointer
// marks the front, so an insert only moves the head back and writes one
// entry. An insert, a rejected insert into a full list and a switch on an
// empty list are answered at once: the result word is registered at the
// same edge that accepts the input word.
// A switch first reduces steps modulo the current length with a bit-serial
// restoring remainder, then reads the picked entry and walks the entries ahead
// of it back by one, one entry per cycle through the single read and write
// port of the memory, and finally writes the picked tag at the front.
// One word is worked on at a time. item_ready is high only while the block is
// idle and its result register is empty or being emptied in that cycle, so a
// stalled receiver holds back the next input word but never loses a result.
// Reset empties the list at once; the memory is never read before written.
`default_nettype none

module move_to_front_recency_list (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic                          func,
    input  wire logic [mtf_pkg::TAG_W-1:0]     tag,
    input  wire logic [mtf_pkg::STEPS_W-1:0]   steps,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [mtf_pkg::TAG_W-1:0]          front_tag,
    output logic [mtf_pkg::LEN_W-1:0]          list_length,
    output logic [mtf_pkg::STAT_W-1:0]         status
);
    import mtf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READP,
        S_PICK,
        S_MOVE,
        S_FIN
    } state_t;

    // Map a position in the list to a memory address, relative to the head.
    function automatic logic [ADDR_W-1:0] phys_addr(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] lpos
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, lpos};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]      head_reg, head_next;
    logic [TAG_W-1:0]       front_reg, front_next;
    logic [STEPS_W-1:0]     quot_reg, quot_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [TAG_W-1:0]       picked_reg, picked_next;
    logic                   result_valid_reg, result_valid_next;
    logic [TAG_W-1:0]       res_front_reg, res_front_next;
    logic [LEN_W-1:0]       res_len_reg, res_len_next;
    status_t                res_status_reg, res_status_next;

    // Tag memory with one write port and one registered read port.
    logic [TAG_W-1:0]       order_mem [DEPTH];
    logic [TAG_W-1:0]       rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [TAG_W-1:0]       mem_wdata;
    logic [ADDR_W-1:0]      rd_lpos;
    logic [ADDR_W-1:0]      mem_raddr;

    logic                   accept;
    logic [CNT_W:0]         trial;
    logic [CNT_W:0]         trial_diff;
    logic [CNT_W-1:0]       rem_step;
    logic [ADDR_W-1:0]      head_dec;

    assign item_ready = (state_reg == S_IDLE) && (!result_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;

    // One step of the restoring remainder: shift in the next bit of steps.
    assign trial      = {rem_reg, quot_reg[STEPS_W-1]};
    assign trial_diff = trial - {1'b0, count_reg};
    assign rem_step   = (trial >= {1'b0, count_reg}) ? trial_diff[CNT_W-1:0]
                                                     : trial[CNT_W-1:0];

    assign head_dec   = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign mem_raddr  = phys_addr(head_reg, rd_lpos);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        head_next         = head_reg;
        front_next        = front_reg;
        quot_next         = quot_reg;
        rem_next          = rem_reg;
        bit_cnt_next      = bit_cnt_reg;
        pos_next          = pos_reg;
        idx_next          = idx_reg;
        picked_next       = picked_reg;
        result_valid_next = result_valid_reg && !result_ready;
        res_front_next    = res_front_reg;
        res_len_next      = res_len_reg;
        res_status_next   = res_status_reg;
        mem_we            = 1'b0;
        mem_waddr         = head_reg;
        mem_wdata         = tag;
        rd_lpos           = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    if (func == FUNC_INSERT) begin
                        result_valid_next = 1'b1;
                        if (count_reg >= CNT_W'(DEPTH)) begin
                            res_front_next  = front_reg;
                            res_len_next    = LEN_W'(count_reg);
                            res_status_next = ST_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            mem_waddr       = head_dec;
                            mem_wdata       = tag;
                            head_next       = head_dec;
                            front_next      = tag;
                            count_next      = count_reg + 1'b1;
                            res_front_next  = tag;
                            res_len_next    = LEN_W'(count_reg + 1'b1);
                            res_status_next = ST_OK;
                        end
                    end else if (count_reg == '0) begin
                        result_valid_next = 1'b1;
                        res_front_next    = '0;
                        res_len_next      = '0;
                        res_status_next   = ST_EMPTY;
                    end else begin
                        quot_next    = steps;
                        rem_next     = '0;
                        bit_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                rem_next     = rem_step;
                quot_next    = {quot_reg[STEPS_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_W'(STEPS_W - 1)) begin
                    pos_next   = ADDR_W'(rem_step);
                    state_next = S_READP;
                end
            end

            S_READP:
            begin
                rd_lpos    = pos_reg;
                state_next = S_PICK;
            end

            S_PICK:
            begin
                picked_next = rd_data_reg;
                if (pos_reg == '0) begin
                    // The picked entry is already at the front.
                    result_valid_next = 1'b1;
                    res_front_next    = front_reg;
                    res_len_next      = LEN_W'(count_reg);
                    res_status_next   = ST_OK;
                    state_next        = S_IDLE;
                end else begin
                    rd_lpos    = pos_reg - 1'b1;
                    idx_next   = pos_reg;
                    state_next = S_MOVE;
                end
            end

            S_MOVE:
            begin
                // The read data is the entry just ahead of idx.
                mem_we    = 1'b1;
                mem_waddr = phys_addr(head_reg, idx_reg);
                mem_wdata = rd_data_reg;
                rd_lpos   = (idx_reg >= ADDR_W'(2)) ? idx_reg - ADDR_W'(2) : '0;
                idx_next  = idx_reg - 1'b1;
                if (idx_reg == ADDR_W'(1)) begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                mem_we            = 1'b1;
                mem_waddr         = head_reg;
                mem_wdata         = picked_reg;
                front_next        = picked_reg;
                result_valid_next = 1'b1;
                res_front_next    = picked_reg;
                res_len_next      = LEN_W'(count_reg);
                res_status_next   = ST_OK;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            order_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= order_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            head_reg         <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            head_reg         <= head_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        bit_cnt_reg    <= bit_cnt_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        picked_reg     <= picked_next;
        res_front_reg  <= res_front_next;
        res_len_reg    <= res_len_next;
        res_status_reg <= res_status_next;
    end

    assign result_valid = result_valid_reg;
    assign front_tag    = res_front_reg;
    assign list_length  = res_len_reg;
    assign status       = res_status_reg;

    // The list never holds more entries than the memory has.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds memory depth");

    // While a switch is being worked on, no result word is pending.
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !result_valid_reg)
        else $error("result pending while a switch is in progress");

    // An accepted insert is answered at the next edge.
    a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_INSERT) |=> (result_valid_reg && state_reg == S_IDLE))
        else $error("insert did not produce a result word");

    // Only an accepted insert changes the length of the list.
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(accept && func == FUNC_INSERT))
        else $error("entry count changed without an insert");

endmodule

`default_nettype wire

// ----- verif/mtf_recency_checker.sv -----
`timescale 1ns / 100ps
// Checker for the move-to-front recency list: predicts every result word and compares it.
module mtf_recency_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  logic                         func,
    input  logic [mtf_pkg::TAG_W-1:0]    tag,
    input  logic [mtf_pkg::STEPS_W-1:0]  steps,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  logic [mtf_pkg::TAG_W-1:0]    front_tag,
    input  logic [mtf_pkg::LEN_W-1:0]    list_length,
    input  logic [mtf_pkg::STAT_W-1:0]   status,
    output int                           fail_count,
    output int                           words_pending
);
    import mtf_pkg::*;

    typedef struct packed {
        logic [TAG_W-1:0] front;
        logic [LEN_W-1:0] len;
        status_t          stat;
    } recency_word_t;

    logic [TAG_W-1:0] recency_list [DEPTH];
    int               held_count;
    int               fails;
    recency_word_t    expected_words [$];

    // Applies one input word to the local copy of the list and returns its result word.
    task automatic apply_recency_op(input logic f, input logic [TAG_W-1:0] t,
                                    input logic [STEPS_W-1:0] s, output recency_word_t w);
        int               pos;
        logic [TAG_W-1:0] picked;
        w.stat = ST_OK;
        if (f == FUNC_INSERT) begin
            if (held_count >= DEPTH)
            begin
                w.stat = ST_FULL;
            end
            else
            begin
                for (int i = held_count; i > 0; i--)
                    recency_list[i] = recency_list[i-1];
                recency_list[0] = t;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            w.stat = ST_EMPTY;
        end
        else
        begin
            pos    = int'(s) % held_count;
            picked = recency_list[pos];
            for (int i = pos; i > 0; i--)
                recency_list[i] = recency_list[i-1];
            recency_list[0] = picked;
        end
        w.front = (held_count > 0) ? recency_list[0] : '0;
        w.len   = LEN_W'(held_count);
    endtask

    // A result word accepted at an edge belongs to an older input word than one
    // accepted at the same edge, so results are checked before the new prediction.
    always @(posedge clk or negedge rst_n)
    begin : watch
        recency_word_t want;
        if (!rst_n)
        begin
            held_count = 0;
            fails      = 0;
            expected_words.delete();
            fail_count    <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: front_tag %h list_length %0d status %0d",
                           front_tag, list_length, status);
                    fails++;
                end
                else
                begin
                    want = expected_words[0];
                    expected_words.delete(0);
                    if (front_tag !== want.front)
                    begin
                        $error("front_tag: expected %h, got %h", want.front, front_tag);
                        fails++;
                    end
                    if (list_length !== want.len)
                    begin
                        $error("list_length: expected %0d, got %0d", want.len, list_length);
                        fails++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, got %0d", want.stat, status);
                        fails++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                apply_recency_op(func, tag, steps, want);
                expected_words.insert(expected_words.size(), want);
            end
            fail_count    <= fails;
            words_pending <= expected_words.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the move-to-front recency list: clock, reset, stimulus and verdict.
module tb;
    import mtf_pkg::*;

    // Cycles with no word accepted on either channel before the run is declared hung.
    localparam int STUCK_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 534;
    localparam int INSERT_PCT    = 30;
    localparam int FULL_INS_PCT  = 15;
    localparam int IDLE_PCT      = 14;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    logic               func         = FUNC_INSERT;
    logic [TAG_W-1:0]   tag          = '0;
    logic [STEPS_W-1:0] steps        = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [TAG_W-1:0]   front_tag;
    logic [LEN_W-1:0]   list_length;
    logic [STAT_W-1:0]  status;

    // While set, neither side inserts idle cycles.
    logic               calm         = 1'b0;
    int                 fail_count;
    int                 words_pending;
    int                 stuck_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    move_to_front_recency_list u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .tag          (tag),
        .steps        (steps),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .front_tag    (front_tag),
        .list_length  (list_length),
        .status       (status)
    );

    mtf_recency_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .func          (func),
        .tag           (tag),
        .steps         (steps),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .front_tag     (front_tag),
        .list_length   (list_length),
        .status        (status),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge clk)
        result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Hang detection: any accepted word on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[move_to_front_recency_list] ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offers one word and returns at the edge where it is accepted. Idle cycles
    // before the word carry junk payload with valid low, which the block must ignore.
    task automatic send_word(input logic f, input logic [TAG_W-1:0] t,
                             input logic [STEPS_W-1:0] s);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            func       <= 1'($urandom);
            tag        <= TAG_W'($urandom);
            steps      <= STEPS_W'($urandom);
            @(posedge clk);
        end
        item_valid <= 1'b1;
        func       <= f;
        tag        <= t;
        steps      <= s;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int                 list_fill;
        logic               is_insert;
        logic [STEPS_W-1:0] hop;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Switches on the empty list, with the smallest and largest step counts.
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'h0000);
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'hFFFF);

        // A single entry: any switch is a zero position.
        send_word(FUNC_INSERT, 16'h0000, STEPS_W'($urandom));
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'h0000);
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'hFFFF);

        // Extreme and alternating tags, then switches across four entries:
        // zero position, next entry, last entry, the largest step count wrapping to
        // the last entry, a count equal to the length wrapping to the front, and a middle entry.
        send_word(FUNC_INSERT, 16'hFFFF, STEPS_W'($urandom));
        send_word(FUNC_INSERT, 16'h5555, STEPS_W'($urandom));
        send_word(FUNC_INSERT, 16'hAAAA, STEPS_W'($urandom));
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'h0000);
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'h0001);
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'h0003);
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'hFFFF);
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'h0004);
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'h0002);

        // Five entries: the last position, then a large count wrapping to zero.
        send_word(FUNC_INSERT, 16'h8001, STEPS_W'($urandom));
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'h0004);
        send_word(FUNC_SWITCH, TAG_W'($urandom), 16'hFFFF);
        list_fill = 5;

        // Random part: the list grows through every length with switches mixed in,
        // then stays full, where inserts are rejected and switches walk far.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
            begin
                // Hold the sender until every outstanding result word has drained.
                item_valid <= 1'b0;
                @(posedge clk);
                while (words_pending != 0)
                    @(posedge clk);
            end
            calm <= (n >= 300) && (n < 400);

            if (list_fill < DEPTH)
                is_insert = ($urandom_range(0, 99) < INSERT_PCT);
            else
                is_insert = ($urandom_range(0, 99) < FULL_INS_PCT);

            case ($urandom_range(0, 5))
                0, 1:    hop = STEPS_W'($urandom);
                2, 3:    hop = STEPS_W'($urandom_range(0, list_fill));
                4:       hop = STEPS_W'(list_fill - 1);
                default: hop = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase

            send_word(is_insert ? FUNC_INSERT : FUNC_SWITCH, TAG_W'($urandom), hop);
            if (is_insert && list_fill < DEPTH)
                list_fill++;
        end

        // Drain: wait for the last result word, then linger for stray outputs.
        item_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("[move_to_front_recency_list] OK");
        else
            $display("[move_to_front_recency_list] ERROR");
        $finish;
    end

endmodule
